>>> src/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
// No dependencies; every other file of the block but bpa_map_ram refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

	localparam int ADDR_W   = 64;
	localparam int FREE_W   = 11;
	localparam int WORD_W   = 32;
	localparam int BIT_IDX_W = 5;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_NO_FREE   = 2'd1,
		ST_FREED     = 2'd2,
		ST_OUTSIDE   = 2'd3
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [ADDR_W-1:0]   page_addr;
		logic [FREE_W-1:0]   free_pages;
	} result_t;

endpackage

`default_nettype wire

>>> src/bpa_req_if.sv
// Request channel of the bitmap page allocator: valid/ready plus request fields.
// Depends on bpa_pkg for the address width.
`timescale 1ns / 1ps
`default_nettype none

interface bpa_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [bpa_pkg::ADDR_W-1:0]  release_addr;

	modport source (output valid, output req_type, output release_addr, input ready);
	modport sink   (input valid, input req_type, input release_addr, output ready);
endinterface

`default_nettype wire

>>> src/bpa_rsp_if.sv
// Response channel of the bitmap page allocator: valid/ready plus result fields.
// Depends on bpa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bpa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [bpa_pkg::ADDR_W-1:0]  page_addr;
	logic [bpa_pkg::FREE_W-1:0]  free_pages;

	modport source (output valid, output status, output page_addr, output free_pages,
		input ready);
	modport sink   (input valid, input status, input page_addr, input free_pages,
		output ready);
endinterface

`default_nettype wire

>>> src/bpa_map_ram.sv
// Used-bit map storage: one write port and one read port with registered read data.
// Standalone; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bpa_map_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> src/bpa_ctrl.sv
// Allocator sequencer: clears the map, scans for free pages, and does the
// read-modify-write of map words. Depends on bpa_pkg, bpa_req_if, bpa_map_ram ports.
`timescale 1ns / 1ps
`default_nettype none

module bpa_ctrl #(
	parameter int NUM_PAGES  = 1024,
	parameter int PAGE_SHIFT = 12,
	parameter int NUM_WORDS  = (NUM_PAGES + bpa_pkg::WORD_W - 1) / bpa_pkg::WORD_W,
	parameter int WA_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	bpa_req_if.sink                          req,
	input  wire logic [bpa_pkg::ADDR_W-1:0]  pool_base,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output bpa_pkg::result_t                 res,
	output logic                             ram_we,
	output logic      [WA_W-1:0]             ram_waddr,
	output logic      [bpa_pkg::WORD_W-1:0]  ram_wdata,
	output logic      [WA_W-1:0]             ram_raddr,
	input  wire logic [bpa_pkg::WORD_W-1:0]  ram_rdata
);

	localparam int CNT_W  = $clog2(NUM_PAGES + 1);
	localparam int HINT_W = $clog2(NUM_WORDS + 1);
	localparam int PI_W   = WA_W + bpa_pkg::BIT_IDX_W;
	localparam int LAST_BITS = NUM_PAGES - (NUM_WORDS - 1) * bpa_pkg::WORD_W;
	localparam logic [bpa_pkg::WORD_W-1:0] PAD_MASK = (LAST_BITS == bpa_pkg::WORD_W) ?
		'0 : ~((32'd1 << LAST_BITS) - 32'd1);
	localparam logic [WA_W-1:0]   LAST_WORD  = WA_W'(NUM_WORDS - 1);
	localparam logic [HINT_W-1:0] WORDS_H    = HINT_W'(NUM_WORDS);
	localparam logic [CNT_W-1:0]  CNT_RESET  = CNT_W'(NUM_PAGES);
	localparam logic [bpa_pkg::ADDR_W-1:0] POOL_SIZE =
		bpa_pkg::ADDR_W'(NUM_PAGES) << PAGE_SHIFT;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_FREE_RD, S_ALLOC_RD, S_ADDR, S_DONE
	} state_t;

	state_t                        state_q;
	logic [WA_W-1:0]               clr_q;
	logic [HINT_W-1:0]             hint_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [bpa_pkg::ADDR_W-1:0]    addr_q;
	logic [WA_W-1:0]               word_q;
	logic [bpa_pkg::BIT_IDX_W-1:0] bit_q;
	bpa_pkg::status_t              status_q;
	logic [bpa_pkg::ADDR_W-1:0]    page_addr_q;

	logic [bpa_pkg::ADDR_W:0]      diff;
	logic                          in_pool;
	logic [PI_W-1:0]               pidx_chk;
	logic [bpa_pkg::WORD_W-1:0]    masked;
	logic [bpa_pkg::WORD_W-1:0]    onehot;
	logic                          word_full;
	logic                          full_after;
	logic [bpa_pkg::BIT_IDX_W-1:0] bit_sel;
	logic [CNT_W+bpa_pkg::FREE_W-1:0] cnt_ext;

	// Pool check: the borrow of the subtraction tells release_addr < pool_base.
	assign diff     = {1'b0, addr_q} - {1'b0, pool_base};
	assign in_pool  = !diff[bpa_pkg::ADDR_W] && (diff[bpa_pkg::ADDR_W-1:0] < POOL_SIZE);
	assign pidx_chk = diff[PAGE_SHIFT +: PI_W];

	// Bits past the last page read as used so the search never lands on them.
	assign masked     = ram_rdata | ((word_q == LAST_WORD) ? PAD_MASK : '0);
	assign onehot     = ~masked & (masked + 32'd1);
	assign word_full  = &masked;
	assign full_after = &(masked | onehot);

	always_comb begin
		bit_sel = '0;
		for (int i = 0; i < bpa_pkg::WORD_W; i++) begin
			if (onehot[i]) begin
				bit_sel = bit_sel | bpa_pkg::BIT_IDX_W'(i);
			end
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = word_q;
		ram_wdata = ram_rdata;
		ram_raddr = hint_q[WA_W-1:0];
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_CHECK: begin
				ram_raddr = pidx_chk[PI_W-1:bpa_pkg::BIT_IDX_W];
			end
			S_ALLOC_RD: begin
				ram_raddr = word_q + WA_W'(1);
				ram_we    = !word_full;
				ram_wdata = ram_rdata | onehot;
			end
			S_FREE_RD: begin
				ram_we    = ram_rdata[bit_q];
				ram_wdata = ram_rdata & ~(32'd1 << bit_q);
			end
			default: begin
			end
		endcase
	end

	assign req.ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign cnt_ext   = {{bpa_pkg::FREE_W{1'b0}}, cnt_q};
	assign res.status     = status_q;
	assign res.page_addr  = page_addr_q;
	assign res.free_pages = cnt_ext[bpa_pkg::FREE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			hint_q  <= '0;
			cnt_q   <= CNT_RESET;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + WA_W'(1);
					if (clr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						addr_q <= req.release_addr;
						if (req.req_type == bpa_pkg::REQ_FREE) begin
							state_q <= S_CHECK;
						end else if (cnt_q == '0) begin
							status_q    <= bpa_pkg::ST_NO_FREE;
							page_addr_q <= '0;
							state_q     <= S_DONE;
						end else begin
							word_q  <= hint_q[WA_W-1:0];
							state_q <= S_ALLOC_RD;
						end
					end
				end
				S_CHECK: begin
					if (!in_pool) begin
						status_q    <= bpa_pkg::ST_OUTSIDE;
						page_addr_q <= '0;
						state_q     <= S_DONE;
					end else begin
						word_q  <= pidx_chk[PI_W-1:bpa_pkg::BIT_IDX_W];
						bit_q   <= pidx_chk[bpa_pkg::BIT_IDX_W-1:0];
						state_q <= S_FREE_RD;
					end
				end
				S_FREE_RD: begin
					if (ram_rdata[bit_q]) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (HINT_W'(word_q) < hint_q) begin
							hint_q <= HINT_W'(word_q);
						end
					end
					status_q    <= bpa_pkg::ST_FREED;
					page_addr_q <= '0;
					state_q     <= S_DONE;
				end
				S_ALLOC_RD: begin
					if (word_full) begin
						if (word_q == LAST_WORD) begin
							status_q    <= bpa_pkg::ST_NO_FREE;
							page_addr_q <= '0;
							state_q     <= S_DONE;
						end else begin
							word_q <= word_q + WA_W'(1);
						end
					end else begin
						cnt_q    <= cnt_q - CNT_W'(1);
						bit_q    <= bit_sel;
						hint_q   <= full_after ? HINT_W'(word_q) + HINT_W'(1) : HINT_W'(word_q);
						status_q <= bpa_pkg::ST_ALLOCATED;
						state_q  <= S_ADDR;
					end
				end
				S_ADDR: begin
					page_addr_q <= pool_base +
						(bpa_pkg::ADDR_W'({word_q, bit_q}) << PAGE_SHIFT);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_RESET)
		else $error("free page count above pool size");

	a_hint_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (hint_q < WORDS_H))
		else $error("search hint past the map while pages are free");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CNT_W'(1)) ||
		(cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("free page count moved by more than one");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == S_CLEAR) || (state_q == S_ALLOC_RD) ||
			(state_q == S_FREE_RD)))
		else $error("map written outside a read-modify-write step");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q != S_IDLE))
		else $error("accepted request did not start");
`endif

endmodule

`default_nettype wire

>>> src/bitmap_page_allocator_core.sv
// Top level of the bitmap page allocator: config register, output register,
// sequencer and map RAM. Depends on bpa_pkg, bpa_req_if, bpa_rsp_if, bpa_ctrl, bpa_map_ram.
//
// The req channel carries one request per transaction: req_type 0 allocates the
// lowest-numbered free page, req_type 1 frees the page holding release_addr. The rsp
// channel returns one result transaction per request, in order: status, the allocated
// page address (zero otherwise) and the free page count. pool_base is written through
// cfg_wr_en / cfg_wr_data; the user must do so only while the block is idle (not enforced).
// A free inside the pool passes the check, read and done states, a free outside the pool
// only check and done. An allocate reads map words from the search hint on, one more read
// per fully used 32-bit map word before the first word with a free page, then forms the
// address; it goes straight to done when no page is free. The hint keeps the usual case to
// a single word read. The next request is taken in the cycle after a result leaves the
// sequencer. arst_n clears control state and pool_base; then a pass writes one map word
// per cycle over all ceil(NUM_PAGES/32) words (32 at the default size), with req.ready low.
// A finished result waits in the output register while rsp.ready is low; the next
// request is still accepted and worked on, and holds in its final step until the
// output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator_core #(
	parameter int NUM_PAGES  = 1024,
	parameter int PAGE_SHIFT = 12
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [bpa_pkg::ADDR_W-1:0]  cfg_wr_data,
	bpa_req_if.sink                          req,
	bpa_rsp_if.source                        rsp
);

	localparam int NUM_WORDS = (NUM_PAGES + bpa_pkg::WORD_W - 1) / bpa_pkg::WORD_W;
	localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

	// Base address of page 0; the user must write it only between requests (not enforced).
	logic [bpa_pkg::ADDR_W-1:0] pool_base_q;

	// Output register that decouples the response side from the sequencer.
	logic                       rsp_valid_q;
	bpa_pkg::result_t           rsp_q;

	logic                       res_valid;
	logic                       res_ready;
	bpa_pkg::result_t           res;

	logic                       ram_we;
	logic [WA_W-1:0]            ram_waddr;
	logic [bpa_pkg::WORD_W-1:0] ram_wdata;
	logic [WA_W-1:0]            ram_raddr;
	logic [bpa_pkg::WORD_W-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
		end else if (cfg_wr_en) begin
			pool_base_q <= cfg_wr_data;
		end
	end

	// The sequencer may hand over a result when the register is empty or being drained.
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_q.status;
	assign rsp.page_addr  = rsp_q.page_addr;
	assign rsp.free_pages = rsp_q.free_pages;

	bpa_ctrl #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_SHIFT (PAGE_SHIFT),
		.NUM_WORDS  (NUM_WORDS),
		.WA_W       (WA_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.pool_base (pool_base_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	bpa_map_ram #(
		.DEPTH (NUM_WORDS),
		.AW    (WA_W),
		.DW    (bpa_pkg::WORD_W)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire
